/* sv/sjf_nonpreemptive_scheduler_assert.svh */
// Assertion macros for the shortest-job-first scheduler.
`ifndef SJF_NONPREEMPTIVE_SCHEDULER_ASSERT_SVH
`define SJF_NONPREEMPTIVE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SJF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SJF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sjf_pkg.sv */
// Types, codes and defaults shared by the shortest-job-first scheduler.
package sjf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF  = 16;
  localparam int unsigned ID_WIDTH_DEF    = 8;
  localparam int unsigned ORDER_WIDTH     = 16;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_ZERO_BURST = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [7:0]  job_id;
    logic [15:0] burst;
  } sjf_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        running_valid;
    logic [7:0]  running_job;
    logic        dispatched;
    logic [15:0] dispatched_wait;
    logic        finished;
    logic [4:0]  waiting_count;
  } sjf_out_t;

  typedef struct packed {
    logic write_en;
    logic clear_en;
    logic tick_en;
  } sjf_cell_ctrl_t;

endpackage

/* sv/sjf_cell.sv */
// One queue slot of the scheduler with its stage of the shortest-job compare chain.
module sjf_cell import sjf_pkg::*; #(
  parameter int unsigned ID_WIDTH   = ID_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int unsigned IDX_WIDTH  = 4,
  parameter int unsigned SLOT       = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sjf_cell_ctrl_t         ctrl_i,
  input  logic [ID_WIDTH-1:0]    wr_job_i,
  input  logic [TIME_WIDTH-1:0]  wr_burst_i,
  input  logic [ORDER_WIDTH-1:0] order_i,
  input  logic [IDX_WIDTH-1:0]   clr_slot_i,
  input  logic                   srch_i,
  output logic                   srch_o,
  output logic                   valid_o,
  input  logic                   c_found_i,
  input  logic [TIME_WIDTH-1:0]  c_burst_i,
  input  logic [ORDER_WIDTH-1:0] c_age_i,
  input  logic [IDX_WIDTH-1:0]   c_slot_i,
  input  logic [ID_WIDTH-1:0]    c_job_i,
  input  logic [TIME_WIDTH-1:0]  c_wait_i,
  output logic                   c_found_o,
  output logic [TIME_WIDTH-1:0]  c_burst_o,
  output logic [ORDER_WIDTH-1:0] c_age_o,
  output logic [IDX_WIDTH-1:0]   c_slot_o,
  output logic [ID_WIDTH-1:0]    c_job_o,
  output logic [TIME_WIDTH-1:0]  c_wait_o
);

  logic                   valid_q, valid_d;
  logic [ID_WIDTH-1:0]    job_q, job_d;
  logic [TIME_WIDTH-1:0]  burst_q, burst_d;
  logic [TIME_WIDTH-1:0]  wait_q, wait_d;
  logic [ORDER_WIDTH-1:0] order_q, order_d;

  logic                   c_found_q;
  logic [TIME_WIDTH-1:0]  c_burst_q;
  logic [ORDER_WIDTH-1:0] c_age_q;
  logic [IDX_WIDTH-1:0]   c_slot_q;
  logic [ID_WIDTH-1:0]    c_job_q;
  logic [TIME_WIDTH-1:0]  c_wait_q;

  logic [ORDER_WIDTH-1:0] age;
  logic                   better;
  logic                   grant;
  logic                   clr_hit;

  assign age     = order_i - order_q;
  assign better  = valid_q && (!c_found_i || (burst_q < c_burst_i) ||
                   ((burst_q == c_burst_i) && (age > c_age_i)));
  assign grant   = ctrl_i.write_en && srch_i && !valid_q;
  assign clr_hit = ctrl_i.clear_en && (clr_slot_i == IDX_WIDTH'(SLOT));
  assign srch_o  = srch_i && valid_q;
  assign valid_o = valid_q;

  always_comb begin
    valid_d = valid_q;
    job_d   = job_q;
    burst_d = burst_q;
    wait_d  = wait_q;
    order_d = order_q;
    if (grant) begin
      valid_d = 1'b1;
      job_d   = wr_job_i;
      burst_d = wr_burst_i;
      wait_d  = '0;
      order_d = order_i;
    end
    if (clr_hit) begin
      valid_d = 1'b0;
    end else if (ctrl_i.tick_en && valid_q && (wait_q != '1)) begin
      wait_d = wait_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      c_found_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      c_found_q <= c_found_i || valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    burst_q <= burst_d;
    wait_q  <= wait_d;
    order_q <= order_d;
    if (better) begin
      c_burst_q <= burst_q;
      c_age_q   <= age;
      c_slot_q  <= IDX_WIDTH'(SLOT);
      c_job_q   <= job_q;
      c_wait_q  <= wait_q;
    end else begin
      c_burst_q <= c_burst_i;
      c_age_q   <= c_age_i;
      c_slot_q  <= c_slot_i;
      c_job_q   <= c_job_i;
      c_wait_q  <= c_wait_i;
    end
  end

  assign c_found_o = c_found_q;
  assign c_burst_o = c_burst_q;
  assign c_age_o   = c_age_q;
  assign c_slot_o  = c_slot_q;
  assign c_job_o   = c_job_q;
  assign c_wait_o  = c_wait_q;

endmodule

/* sv/sjf_nonpreemptive_scheduler.sv */
// Arrive, or tick that dispatches nothing: an accepted item goes from ST_IDLE to ST_EMIT, and
// the result is registered when the output is free. Tick that dispatches: ST_IDLE, ST_SCAN
// and ST_EMIT; the compare chain advances one slot a cycle. An item is taken only in
// ST_IDLE; a result may wait while the next item is accepted. Reset: asynchronous, queue
// empty, processor idle, no clearing pass.
// Top level of the non-preemptive shortest-job-first scheduler.
module sjf_nonpreemptive_scheduler import sjf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int unsigned ID_WIDTH    = ID_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sjf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sjf_out_t out_data_o
);

`include "sjf_nonpreemptive_scheduler_assert.svh"

  localparam int unsigned IDX_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [IDX_WIDTH-1:0]   scan_q, scan_d;
  logic                   op_q;
  logic [ID_WIDTH-1:0]    id_q;
  logic [TIME_WIDTH-1:0]  burst_q;
  logic                   zero_q;
  logic [ORDER_WIDTH-1:0] arr_q, arr_d;
  logic [ID_WIDTH-1:0]    cur_q, cur_d;
  logic [TIME_WIDTH-1:0]  tl_q, tl_d;
  logic [CNT_WIDTH-1:0]   count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  sjf_out_t               out_q, out_d;

  logic [ID_WIDTH+7:0]    id_ext;
  logic [TIME_WIDTH+15:0] burst_ext;
  logic [TIME_WIDTH-1:0]  burst_sat;
  logic                   accept;
  logic                   out_free;
  logic                   commit;
  logic                   disp;
  logic                   full;
  logic [TIME_WIDTH-1:0]  tl_eff;
  logic [ID_WIDTH-1:0]    cur_eff;
  logic [TIME_WIDTH+15:0] wait_ext;
  logic [ID_WIDTH+7:0]    cur_ext;
  logic [CNT_WIDTH+4:0]   cnt_ext;
  sjf_cell_ctrl_t         ctrl;

  logic [QUEUE_DEPTH:0]   srch;
  logic [QUEUE_DEPTH-1:0] valid_vec;
  logic                   c_found [QUEUE_DEPTH+1];
  logic [TIME_WIDTH-1:0]  c_burst [QUEUE_DEPTH+1];
  logic [ORDER_WIDTH-1:0] c_age   [QUEUE_DEPTH+1];
  logic [IDX_WIDTH-1:0]   c_slot  [QUEUE_DEPTH+1];
  logic [ID_WIDTH-1:0]    c_job   [QUEUE_DEPTH+1];
  logic [TIME_WIDTH-1:0]  c_wait  [QUEUE_DEPTH+1];

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_EMIT) && out_free;
  assign disp       = (op_q == OP_TICK) && (tl_q == '0) && (count_q != '0);
  assign full       = srch[QUEUE_DEPTH];

  assign id_ext    = {{ID_WIDTH{1'b0}}, in_data_i.job_id};
  assign burst_ext = {{TIME_WIDTH{1'b0}}, in_data_i.burst};
  assign burst_sat = (burst_ext[TIME_WIDTH+15:TIME_WIDTH] != '0) ? '1
                                                               : burst_ext[TIME_WIDTH-1:0];

  assign ctrl.write_en = commit && (op_q == OP_ARRIVE) && !zero_q;
  assign ctrl.clear_en = commit && disp;
  assign ctrl.tick_en  = commit && (op_q == OP_TICK);

  assign srch[0]    = 1'b1;
  assign c_found[0] = 1'b0;
  assign c_burst[0] = '0;
  assign c_age[0]   = '0;
  assign c_slot[0]  = '0;
  assign c_job[0]   = '0;
  assign c_wait[0]  = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    sjf_cell #(
      .ID_WIDTH  (ID_WIDTH),
      .TIME_WIDTH(TIME_WIDTH),
      .IDX_WIDTH (IDX_WIDTH),
      .SLOT      (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_job_i  (id_q),
      .wr_burst_i(burst_q),
      .order_i   (arr_q),
      .clr_slot_i(c_slot[QUEUE_DEPTH]),
      .srch_i    (srch[i]),
      .srch_o    (srch[i+1]),
      .valid_o   (valid_vec[i]),
      .c_found_i (c_found[i]),
      .c_burst_i (c_burst[i]),
      .c_age_i   (c_age[i]),
      .c_slot_i  (c_slot[i]),
      .c_job_i   (c_job[i]),
      .c_wait_i  (c_wait[i]),
      .c_found_o (c_found[i+1]),
      .c_burst_o (c_burst[i+1]),
      .c_age_o   (c_age[i+1]),
      .c_slot_o  (c_slot[i+1]),
      .c_job_o   (c_job[i+1]),
      .c_wait_o  (c_wait[i+1])
    );
  end

  assign tl_eff   = disp ? c_burst[QUEUE_DEPTH] : tl_q;
  assign cur_eff  = disp ? c_job[QUEUE_DEPTH] : cur_q;
  assign wait_ext = {16'd0, c_wait[QUEUE_DEPTH]};
  assign cur_ext  = {8'd0, cur_d};
  assign cnt_ext  = {5'd0, count_d};

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    arr_d       = arr_q;
    cur_d       = cur_q;
    tl_d        = tl_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          scan_d = '0;
          if ((in_data_i.operation == OP_TICK) && (tl_q == '0) && (count_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == IDX_WIDTH'(QUEUE_DEPTH - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = STATUS_OK;
          if (op_q == OP_ARRIVE) begin
            if (zero_q) begin
              out_d.status = STATUS_ZERO_BURST;
            end else if (full) begin
              out_d.status = STATUS_FULL;
            end else begin
              arr_d   = arr_q + 1'b1;
              count_d = count_q + 1'b1;
            end
          end else begin
            if (disp) begin
              count_d               = count_q - 1'b1;
              out_d.dispatched      = 1'b1;
              out_d.dispatched_wait = (wait_ext[TIME_WIDTH+15:16] != '0) ? 16'hFFFF
                                                                         : wait_ext[15:0];
            end
            cur_d = cur_eff;
            tl_d  = tl_eff;
            if (tl_eff != '0) begin
              tl_d = tl_eff - 1'b1;
              if (tl_eff == TIME_WIDTH'(1)) begin
                out_d.finished = 1'b1;
                cur_d          = '0;
              end
            end
          end
          out_d.running_valid = (tl_d != '0);
          out_d.running_job   = (tl_d != '0) ? cur_ext[7:0] : 8'd0;
          out_d.waiting_count = cnt_ext[4:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      arr_q       <= '0;
      cur_q       <= '0;
      tl_q        <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      arr_q       <= arr_d;
      cur_q       <= cur_d;
      tl_q        <= tl_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      op_q    <= in_data_i.operation;
      id_q    <= id_ext[ID_WIDTH-1:0];
      burst_q <= burst_sat;
      zero_q  <= (in_data_i.burst == 16'd0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SJF_ASSERT_NOW(a_count_matches_slots, 1'b1, $countones(valid_vec) == int'(count_q), "queue count disagrees with slot valid bits")
  `SJF_ASSERT_NOW(a_dispatch_has_candidate, commit && disp, c_found[QUEUE_DEPTH], "dispatch without a candidate at the end of the chain")
  `SJF_ASSERT_NOW(a_result_after_emit, $rose(out_valid_q), $past(state_q) == ST_EMIT, "result beat raised outside of emit")
  `SJF_ASSERT_NEXT(a_no_accept_while_busy, accept, in_stall_o, "input taken while an item is in flight")

endmodule

/* dv/tb_sjf_nonpreemptive_scheduler.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the shortest-job-first scheduler with a predicting scoreboard.
module tb_sjf_nonpreemptive_scheduler;
  import sjf_pkg::*;

  localparam int unsigned DEPTH       = QUEUE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BEATS = 225;
  localparam logic [15:0] WAIT_MAX    = 16'hFFFF;

  class sjf_scoreboard;
    sjf_out_t    expected_q[$];
    int unsigned fail_cnt;
    bit          q_used[DEPTH];
    logic [7:0]  q_id[DEPTH];
    logic [15:0] q_len[DEPTH];
    logic [15:0] q_waited[DEPTH];
    logic [15:0] q_seq[DEPTH];
    logic [15:0] seq_ctr;
    logic [7:0]  run_id;
    logic [15:0] run_left;

    function new();
      fail_cnt = 0;
      seq_ctr  = '0;
      run_id   = '0;
      run_left = '0;
      foreach (q_used[i]) q_used[i] = 1'b0;
    endfunction

    function int unsigned queued();
      int unsigned n;
      n = 0;
      foreach (q_used[i]) n += q_used[i];
      return n;
    endfunction

    function void record_item(sjf_in_t it);
      sjf_out_t    r;
      int          slot;
      int          best;
      logic [15:0] age;
      logic [15:0] best_age;
      r        = '0;
      slot     = -1;
      best     = -1;
      best_age = '0;
      if (it.operation == OP_ARRIVE) begin
        if (it.burst == '0) begin
          r.status = STATUS_ZERO_BURST;
        end else begin
          for (int i = 0; i < DEPTH; i++)
            if (!q_used[i] && slot < 0) slot = i;
          if (slot < 0) begin
            r.status = STATUS_FULL;
          end else begin
            q_used[slot]   = 1'b1;
            q_id[slot]     = it.job_id;
            q_len[slot]    = it.burst;
            q_waited[slot] = '0;
            q_seq[slot]    = seq_ctr;
            seq_ctr        = seq_ctr + 16'd1;
          end
        end
      end else begin
        if (run_left == 0) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (q_used[i]) begin
              age = seq_ctr - q_seq[i];
              if (best < 0 || q_len[i] < q_len[best] ||
                  (q_len[i] == q_len[best] && age > best_age)) begin
                best     = i;
                best_age = age;
              end
            end
          end
          if (best >= 0) begin
            q_used[best]      = 1'b0;
            run_id            = q_id[best];
            run_left          = q_len[best];
            r.dispatched      = 1'b1;
            r.dispatched_wait = q_waited[best];
          end
        end
        foreach (q_used[i])
          if (q_used[i] && q_waited[i] != WAIT_MAX) q_waited[i] = q_waited[i] + 16'd1;
        if (run_left != 0) begin
          run_left = run_left - 16'd1;
          if (run_left == 0) begin
            r.finished = 1'b1;
            run_id     = '0;
          end
        end
      end
      r.running_valid = run_left != 0;
      r.running_job   = run_left != 0 ? run_id : 8'd0;
      r.waiting_count = 5'(queued());
      expected_q.push_back(r);
    endfunction

    function void field_check(string fname, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        fail_cnt++;
        if (fail_cnt <= 40)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, exp_v, got_v);
      end
    endfunction

    function void check_result(sjf_out_t got);
      sjf_out_t exp_r;
      if (expected_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 40)
          $display("%0t: result with none pending, expected nothing actual %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      field_check("status", exp_r.status, got.status);
      field_check("running_valid", exp_r.running_valid, got.running_valid);
      field_check("running_job", exp_r.running_job, got.running_job);
      field_check("dispatched", exp_r.dispatched, got.dispatched);
      field_check("dispatched_wait", exp_r.dispatched_wait, got.dispatched_wait);
      field_check("finished", exp_r.finished, got.finished);
      field_check("waiting_count", exp_r.waiting_count, got.waiting_count);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  sjf_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  sjf_out_t    out_data_o;

  sjf_scoreboard sb;
  int unsigned   idle_pct  = 0;
  int unsigned   stall_pct = 0;
  int unsigned   hold_left = 0;
  int unsigned   cycle_cnt = 0;

  sjf_nonpreemptive_scheduler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_sjf_nonpreemptive_scheduler NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= $urandom_range(0, 99) < stall_pct;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  function automatic sjf_in_t item_of(logic op, logic [7:0] id, logic [15:0] len);
    sjf_in_t it;
    it.operation = op;
    it.job_id    = id;
    it.burst     = len;
    return it;
  endfunction

  function automatic sjf_in_t rand_item(int unsigned tick_pct);
    sjf_in_t it;
    it.operation = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_ARRIVE;
    it.job_id    = 8'($urandom());
    case ($urandom_range(0, 19))
      0: it.burst = '0;
      1: it.burst = 16'($urandom_range(9, 40));
      default: it.burst = 16'($urandom_range(1, 8));
    endcase
    return it;
  endfunction

  task automatic send_item(sjf_in_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.record_item(it);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  initial begin
    int unsigned tick_pct;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(item_of(OP_TICK, 8'hFF, 16'hFFFF));
    send_item(item_of(OP_ARRIVE, 8'hFF, 16'h0000));
    send_item(item_of(OP_ARRIVE, 8'h00, 16'h0001));
    send_item(item_of(OP_TICK, 8'h00, 16'h0000));
    for (int k = 0; k < DEPTH; k++)
      send_item(item_of(OP_ARRIVE, 8'(k * 17), 16'(1 + k % 4)));
    send_item(item_of(OP_ARRIVE, 8'hAA, 16'h8000));
    send_item(item_of(OP_ARRIVE, 8'h55, 16'h0000));
    repeat (3) send_item(item_of(OP_TICK, 8'h00, 16'h0000));
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      if (ph == 1) hold_left <= HOLD_CYCLES;
      tick_pct = 60;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n % 50 == 0) tick_pct = 40 + 20 * $urandom_range(0, 2);
        send_item(rand_item(tick_pct));
      end
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fail_cnt == 0 && sb.expected_q.size() == 0) begin
      $display("tb_sjf_nonpreemptive_scheduler OK");
    end else begin
      $display("tb_sjf_nonpreemptive_scheduler NOT OK");
    end
    $finish;
  end

endmodule
